[rtl/swcme_pkg.sv]
// ---------------------------------------------------------------------------
// swcme_pkg
// Shared types and codes for the sliding window count mex engine.
// ---------------------------------------------------------------------------
package swcme_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    TBL_IN   = 2'd0,
    TBL_OUT  = 2'd1,
    TBL_SCAN = 2'd2
  } tbl_op_t;

  typedef struct packed {
    logic    go;
    tbl_op_t op;
  } tbl_req_t;

  typedef struct packed {
    logic idle;
  } tbl_stat_t;

endpackage

[rtl/sliding_window_count_mex_engine.sv]
// ---------------------------------------------------------------------------
// sliding_window_count_mex_engine
// Windowed occurrence counting over a position store, with mex of counts.
// ---------------------------------------------------------------------------
// One item at a time. After reset the block clears its memories before
// taking items. A write outside the window only updates the position
// store; one inside it also removes the old value from the tables and adds
// the new one. A query moves the window edges one position at a time
// (sequence read, then a read-modify-write of the occurrence entry and up
// to two count entries), then runs the mex scan of the count memory.
// ---------------------------------------------------------------------------
module sliding_window_count_mex_engine #(
  parameter int SEQ_DEPTH   = 1024,
  parameter int VALUE_COUNT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [10:0] left_pos,
  input  logic [10:0] right_pos,
  input  logic [9:0]  value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] mex_count
);
  import swcme_pkg::*;

  localparam int VW = $clog2(VALUE_COUNT);
  localparam int PW = $clog2(SEQ_DEPTH + 2);
  localparam int AW = $clog2(SEQ_DEPTH);

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_STEP  = 11'b00000000100,
    S_RD    = 11'b00000001000,
    S_GO    = 11'b00000010000,
    S_WAIT  = 11'b00000100000,
    S_WIN   = 11'b00001000000,
    S_WWAIT = 11'b00010000000,
    S_WRITE = 11'b00100000000,
    S_SCAN  = 11'b01000000000,
    S_SWAIT = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [VW-1:0] seq [SEQ_DEPTH];
  logic [VW-1:0] seq_rd;

  logic [AW-1:0] clr;
  logic [AW-1:0] addr;
  logic [PW-1:0] wl;
  logic [PW-1:0] wr;
  logic [PW-1:0] ql;
  logic [PW-1:0] qr;
  logic [VW-1:0] wval;
  tbl_op_t       step_op;
  logic          is_wr;

  tbl_req_t       treq;
  tbl_stat_t      tstat;
  logic [VW-1:0]  tval;
  logic [PW-1:0]  tk;

  logic [31:0] lp32, rp32, r32, l32;
  logic        accept, wr_ok, in_win, out_load;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && tstat.idle;
  assign out_load = (state == S_SWAIT) && tstat.idle && (!out_valid || out_ready);

  always_comb begin
    lp32 = 32'(left_pos);
    rp32 = 32'(right_pos);
    r32  = (rp32 > SEQ_DEPTH) ? 32'(SEQ_DEPTH) : rp32;
    l32  = (lp32 == 0) ? 32'd1 : lp32;
    if (l32 > r32 + 32'd1) l32 = r32 + 32'd1;
    wr_ok  = (lp32 >= 32'd1) && (lp32 <= SEQ_DEPTH) && (32'(value) < VALUE_COUNT);
    in_win = (32'(wl) <= lp32) && (lp32 <= 32'(wr));
  end

  always_comb begin
    treq.go = 1'b0;
    treq.op = step_op;
    tval    = seq_rd;
    unique case (state)
      S_GO: treq.go = 1'b1;
      S_WIN: begin
        treq.go = 1'b1;
        treq.op = TBL_IN;
        tval    = wval;
      end
      S_SCAN: begin
        treq.go = 1'b1;
        treq.op = TBL_SCAN;
      end
      default: treq.go = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:   if (32'(clr) == SEQ_DEPTH - 1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_QUERY) state_next = S_STEP;
          else if (wr_ok) state_next = in_win ? S_RD : S_WRITE;
        end
      end
      S_STEP: begin
        if (wl > ql || wr < qr || wl < ql || wr > qr) state_next = S_RD;
        else state_next = S_SCAN;
      end
      S_RD:    state_next = S_GO;
      S_GO:    state_next = S_WAIT;
      S_WAIT:  if (tstat.idle) state_next = is_wr ? S_WIN : S_STEP;
      S_WIN:   state_next = S_WWAIT;
      S_WWAIT: if (tstat.idle) state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      S_SCAN:  state_next = S_SWAIT;
      S_SWAIT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR) seq[clr] <= '0;
    else if (state == S_WRITE) seq[addr] <= wval;
    seq_rd <= seq[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      wl        <= PW'(1);
      wr        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr <= clr + AW'(1);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_STEP) begin
        if (wl > ql) wl <= wl - PW'(1);
        else if (wr < qr) wr <= wr + PW'(1);
        else if (wl < ql) wl <= wl + PW'(1);
        else if (wr > qr) wr <= wr - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ql      <= PW'(l32);
      qr      <= PW'(r32);
      wval    <= VW'(value);
      is_wr   <= (cmd == CMD_WRITE);
      addr    <= AW'(lp32 - 32'd1);
      step_op <= TBL_OUT;
    end
    if (state == S_STEP) begin
      if (wl > ql) begin
        addr    <= AW'(32'(wl) - 32'd2);
        step_op <= TBL_IN;
      end else if (wr < qr) begin
        addr    <= AW'(wr);
        step_op <= TBL_IN;
      end else if (wl < ql) begin
        addr    <= AW'(32'(wl) - 32'd1);
        step_op <= TBL_OUT;
      end else begin
        addr    <= AW'(32'(wr) - 32'd1);
        step_op <= TBL_OUT;
      end
    end
    if (out_load) mex_count <= 11'(tk);
  end

  swcme_tables #(
    .SEQ_DEPTH   (SEQ_DEPTH),
    .VALUE_COUNT (VALUE_COUNT)
  ) u_tables (
    .clk  (clk),
    .rst  (rst),
    .req  (treq),
    .val  (tval),
    .stat (tstat),
    .k    (tk)
  );

endmodule

[rtl/swcme_tables.sv]
// ---------------------------------------------------------------------------
// swcme_tables
// Occurrence and count-of-counts memories with add, remove and mex scan.
// ---------------------------------------------------------------------------
module swcme_tables #(
  parameter int SEQ_DEPTH   = 1024,
  parameter int VALUE_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  swcme_pkg::tbl_req_t                 req,
  input  logic [$clog2(VALUE_COUNT)-1:0]      val,
  output swcme_pkg::tbl_stat_t                stat,
  output logic [$clog2(SEQ_DEPTH+2)-1:0]      k
);
  import swcme_pkg::*;

  localparam int VW    = $clog2(VALUE_COUNT);
  localparam int PW    = $clog2(SEQ_DEPTH + 2);
  localparam int OW    = $clog2(SEQ_DEPTH + 1);
  localparam int CW    = $clog2(VALUE_COUNT + 1);
  localparam int POP_N = SEQ_DEPTH + 2;
  localparam int CLR_N = (VALUE_COUNT > POP_N) ? VALUE_COUNT : POP_N;
  localparam int CLW   = $clog2(CLR_N);

  typedef enum logic [8:0] {
    S_CLR    = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_OCC    = 9'b000000100,
    S_POP0   = 9'b000001000,
    S_DEC    = 9'b000010000,
    S_INC_RD = 9'b000100000,
    S_INC    = 9'b001000000,
    S_SRD    = 9'b010000000,
    S_SCHK   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [OW-1:0] occ [VALUE_COUNT];
  logic [CW-1:0] pop [POP_N];
  logic [OW-1:0] occ_rd;
  logic [CW-1:0] pop_rd;

  logic [CLW-1:0] clr;
  logic [VW-1:0]  v;
  tbl_op_t        op;
  logic [PW-1:0]  o_r;
  logic [PW-1:0]  nw;

  logic [PW-1:0] o_c;
  logic          occ_we;
  logic [VW-1:0] occ_wa;
  logic [OW-1:0] occ_wd;
  logic          pop_we;
  logic [PW-1:0] pop_wa;
  logic [CW-1:0] pop_wd;
  logic [PW-1:0] pop_ra;

  assign o_c       = PW'(occ_rd);
  assign stat.idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    occ_we = 1'b0;
    occ_wa = v;
    occ_wd = OW'(nw);
    pop_we = 1'b0;
    pop_wa = o_r;
    pop_wd = pop_rd - CW'(1);
    pop_ra = o_r;
    unique case (state)
      S_CLR: begin
        occ_we = (32'(clr) < VALUE_COUNT);
        occ_wa = VW'(clr);
        occ_wd = '0;
        pop_we = (32'(clr) < POP_N);
        pop_wa = PW'(clr);
        pop_wd = '0;
        if (32'(clr) == CLR_N - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.go) state_next = (req.op == TBL_SCAN) ? S_SRD : S_OCC;
      end
      S_OCC: state_next = S_POP0;
      S_POP0: begin
        pop_ra = o_c;
        occ_we = !(op == TBL_OUT && occ_rd == '0);
        occ_wd = (op == TBL_IN) ? OW'(o_c + PW'(1)) : OW'(o_c - PW'(1));
        if (occ_rd != '0) state_next = S_DEC;
        else if (op == TBL_IN) state_next = S_INC_RD;
        else state_next = S_IDLE;
      end
      S_DEC: begin
        pop_we = 1'b1;
        pop_wa = o_r;
        pop_wd = pop_rd - CW'(1);
        pop_ra = nw;
        state_next = (nw != '0) ? S_INC : S_IDLE;
      end
      S_INC_RD: begin
        pop_ra = nw;
        state_next = S_INC;
      end
      S_INC: begin
        pop_we = 1'b1;
        pop_wa = nw;
        pop_wd = pop_rd + CW'(1);
        state_next = S_IDLE;
      end
      S_SRD: begin
        pop_ra = k;
        state_next = (32'(k) > SEQ_DEPTH) ? S_IDLE : S_SCHK;
      end
      S_SCHK: begin
        state_next = (pop_rd == '0) ? S_IDLE : S_SRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ[occ_wa] <= occ_wd;
    occ_rd <= occ[v];
    if (pop_we) pop[pop_wa] <= pop_wd;
    pop_rd <= pop[pop_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr <= clr + CLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.go) begin
      v  <= val;
      op <= req.op;
      k  <= PW'(1);
    end
    if (state == S_POP0) begin
      o_r <= o_c;
      nw  <= (op == TBL_IN) ? o_c + PW'(1) : o_c - PW'(1);
    end
    if (state == S_SCHK && pop_rd != '0) k <= k + PW'(1);
  end

endmodule

[verif/tb_sliding_window_count_mex_engine.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sliding_window_count_mex_engine
// Self-checking bench for the windowed occurrence count mex engine. Write
// and query beats are driven in random bursts. Each accepted beat updates a
// local model of the position store, the occurrence table and the
// count-of-counts table. Each query pushes its predicted mex. Returned
// results are compared in order under a random output stall.
// ---------------------------------------------------------------------------
module tb_sliding_window_count_mex_engine;
  import swcme_pkg::*;

  localparam int DEPTH  = 1024;
  localparam int VALUES = 1024;

  typedef struct packed {
    logic        op;
    logic [10:0] lp;
    logic [10:0] rp;
    logic [9:0]  val;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_WRITE;
  logic [10:0] left_pos = '0;
  logic [10:0] right_pos = '0;
  logic [9:0]  value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] mex_count;

  beat_t       pending_beats[$];
  logic [10:0] mex_expected[$];
  int          err_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          cycle_cnt = 0;

  int seq_val[DEPTH];
  int occ[VALUES];
  int pop[DEPTH + 2];
  int win_l = 1;
  int win_r = 0;

  sliding_window_count_mex_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .left_pos(left_pos), .right_pos(right_pos), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .mex_count(mex_count)
  );

  always #5 clk = ~clk;

  function automatic void add_value(int v);
    int o;
    o = occ[v];
    if (o > DEPTH) return;
    if (o >= 1) pop[o]--;
    o++;
    occ[v] = o;
    pop[o]++;
  endfunction

  function automatic void drop_value(int v);
    int o;
    o = occ[v];
    if (o == 0 || o > DEPTH + 1) return;
    pop[o]--;
    o--;
    occ[v] = o;
    if (o >= 1) pop[o]++;
  endfunction

  function automatic int stored_at(int p);
    if (p < 1 || p > DEPTH) return 0;
    return seq_val[p - 1];
  endfunction

  function automatic void apply_beat(beat_t b);
    int l, r, k;
    if (b.op == CMD_WRITE) begin
      l = int'(b.lp);
      if (l < 1 || l > DEPTH) return;
      if (win_l <= l && l <= win_r) begin
        drop_value(seq_val[l - 1]);
        add_value(int'(b.val));
      end
      seq_val[l - 1] = int'(b.val);
    end else begin
      l = int'(b.lp);
      r = int'(b.rp);
      if (l < 1) l = 1;
      if (r > DEPTH) r = DEPTH;
      if (l > r + 1) l = r + 1;
      while (win_l > l) begin win_l--; add_value(stored_at(win_l)); end
      while (win_r < r) begin win_r++; add_value(stored_at(win_r)); end
      while (win_l < l) begin drop_value(stored_at(win_l)); win_l++; end
      while (win_r > r) begin drop_value(stored_at(win_r)); win_r--; end
      k = 1;
      while (k <= DEPTH && pop[k] != 0) k++;
      mex_expected.insert(mex_expected.size(), k[10:0]);
    end
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic beat_t make_beat(logic op, int lp, int rp, int val);
    beat_t b;
    b.op  = op;
    b.lp  = lp[10:0];
    b.rp  = rp[10:0];
    b.val = val[9:0];
    return b;
  endfunction

  function automatic void add_beat(beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // driver: advance to the next beat once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_beats.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        beat_t b;
        b = pending_beats.pop_front();
        in_valid  <= 1'b1;
        cmd       <= b.op;
        left_pos  <= b.lp;
        right_pos <= b.rp;
        value     <= b.val;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor: predict on input beats, check output beats, stall at random
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst) begin
      if (in_valid && in_ready)
        apply_beat(make_beat(cmd, int'(left_pos), int'(right_pos), int'(value)));
      if (out_valid && out_ready) begin
        if (mex_expected.size() == 0)
          report($sformatf("unexpected mex_count %0d", mex_count));
        else begin
          logic [10:0] want;
          want = mex_expected.pop_front();
          if (mex_count !== want)
            report($sformatf("mex_count %0d, expected %0d", mex_count, want));
        end
      end
    end
    case (cycle_cnt[12:11])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= cycle_cnt[3];
    endcase
  end

  initial begin
    int gl, gr, l, r, p, vmax;
    // empty window, extremes, clamping and ignored writes
    add_beat(make_beat(CMD_QUERY, 1, 0, 0));
    add_beat(make_beat(CMD_WRITE, 1, 0, 1023));
    add_beat(make_beat(CMD_WRITE, 1024, 2047, 1023));
    add_beat(make_beat(CMD_WRITE, 0, 0, 5));
    add_beat(make_beat(CMD_WRITE, 1025, 0, 5));
    add_beat(make_beat(CMD_WRITE, 2047, 0, 5));
    add_beat(make_beat(CMD_QUERY, 1, 1, 0));
    add_beat(make_beat(CMD_QUERY, 0, 2047, 1023));
    add_beat(make_beat(CMD_WRITE, 2, 0, 1023));
    add_beat(make_beat(CMD_WRITE, 1024, 0, 0));
    add_beat(make_beat(CMD_QUERY, 1024, 1024, 0));
    add_beat(make_beat(CMD_QUERY, 2047, 5, 0));
    add_beat(make_beat(CMD_QUERY, 3, 2, 0));
    add_beat(make_beat(CMD_QUERY, 1, 3, 0));
    add_beat(make_beat(CMD_WRITE, 3, 0, 1023));
    add_beat(make_beat(CMD_QUERY, 1, 8, 0));
    add_beat(make_beat(CMD_QUERY, 1025, 1024, 0));
    gl = 1;
    gr = 0;
    repeat (1600) begin
      vmax = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(1, 7);
      if ($urandom_range(0, 99) == 0) begin
        add_beat(make_beat(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 1023)));
        gl = 1;
        gr = 0;
      end else if ($urandom_range(0, 1) == 0) begin
        p = (gr >= gl && $urandom_range(0, 2) != 0) ? $urandom_range(gl, gr)
                                                     : $urandom_range(1, 1024);
        add_beat(make_beat(CMD_WRITE, p, $urandom_range(0, 2047),
                           $urandom_range(0, vmax)));
      end else begin
        l = gl + $urandom_range(0, 16) - 8;
        r = gr + $urandom_range(0, 20) - 8;
        if (l < 0) l = 0;
        if (r < 0) r = 0;
        if (r > 1100) r = 1100;
        if (l > 1100) l = 1100;
        add_beat(make_beat(CMD_QUERY, l, r, $urandom_range(0, 1023)));
        gr = (r > 1024) ? 1024 : r;
        gl = (l < 1) ? 1 : l;
        if (gl > gr + 1) gl = gr + 1;
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_beats.size() == 0 && !in_valid && mex_expected.size() == 0);
    repeat (20000) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
